// ----- rtl/invc_pkg.sv -----
package invc_pkg;

   // Width and ceiling of the running inversion total
   localparam int TOTAL_W = 11;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Control bits that travel down the cell row with each request
   typedef struct packed {
      logic valid;   // slot holds a request
      logic last;    // final element of the sequence
      logic ovf;     // element arrived past capacity: not compared, not stored
   } ctrl_type;

endpackage

// ----- rtl/invc_req_if.sv -----
interface invc_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;
   logic                   last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/invc_rsp_if.sv -----
interface invc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [invc_pkg::TOTAL_W-1:0] inversion_total;
   logic                         overflowed;

   modport source (output valid, output inversion_total, output overflowed, input ready);
   modport sink   (input valid, input inversion_total, input overflowed, output ready);
endinterface

// ----- rtl/invc_cell.sv -----
// One cell of the row: holds the element whose sequence position equals
// CELL_INDEX, counts it against every later element passing by.
module invc_cell #(
   parameter int CELL_INDEX = 0,
   parameter int KEY_W      = 32,
   parameter int IDX_W      = 6,
   parameter int GREATER_W  = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  invc_pkg::ctrl_type        ctrl_in,
   input  logic [IDX_W-1:0]          index_in,
   input  logic [KEY_W-1:0]          key_in,
   input  logic [GREATER_W-1:0]      greater_in,
   output invc_pkg::ctrl_type        ctrl_out,
   output logic [IDX_W-1:0]          index_out,
   output logic [KEY_W-1:0]          key_out,
   output logic [GREATER_W-1:0]      greater_out
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);

   invc_pkg::ctrl_type      ctrl_ff;
   logic [IDX_W-1:0]        index_ff;
   logic [KEY_W-1:0]        key_ff;
   logic [GREATER_W-1:0]    greater_ff, greater_in_next;
   logic [KEY_W-1:0]        stored_ff;
   logic                    active;
   logic                    hit;

   // Only in-capacity requests touch the stored element
   assign active = ctrl_in.valid && !ctrl_in.ovf;
   assign hit    = active && (index_in > MY_INDEX) && (stored_ff > key_in);
   assign greater_in_next = hit ? greater_in + GREATER_W'(1) : greater_in;

   // Control slot
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (enable) begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Payload slot and stored element
   always_ff @(posedge clock) begin
      if (enable) begin
         index_ff   <= index_in;
         key_ff     <= key_in;
         greater_ff <= greater_in_next;
         if (active && index_in == MY_INDEX) begin
            stored_ff <= key_in;
         end
      end
   end

   assign ctrl_out    = ctrl_ff;
   assign index_out   = index_ff;
   assign key_out     = key_ff;
   assign greater_out = greater_ff;

   // A request never counts more elements than precede it
   a_greater_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.valid && !ctrl_ff.ovf) |-> (greater_ff <= GREATER_W'(index_ff)))
      else $error("cell count exceeds element position");

endmodule

// ----- rtl/invc_tail.sv -----
// End of the row: folds each request's count into the sequence total and
// holds the result until it is taken.
module invc_tail #(
   parameter int GREATER_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  invc_pkg::ctrl_type    ctrl_in,
   input  logic [GREATER_W-1:0]  greater_in,
   invc_rsp_if.source            rsp_if
);

   localparam int TW    = invc_pkg::TOTAL_W;
   localparam int SUM_W = ((GREATER_W > TW) ? GREATER_W : TW) + 1;

   logic [TW-1:0]    total_ff;
   logic             ovf_ff;
   logic             rsp_valid_ff;
   logic [TW-1:0]    rsp_total_ff;
   logic             rsp_ovf_ff;
   logic [SUM_W-1:0] sum_wide;
   logic [TW-1:0]    total_in;
   logic             ovf_in;
   logic             take;

   // Saturating add of this request's count
   assign sum_wide = SUM_W'(total_ff) + SUM_W'(greater_in);
   assign total_in = (sum_wide > SUM_W'(invc_pkg::TOTAL_MAX)) ?
                     invc_pkg::TOTAL_MAX : sum_wide[TW-1:0];
   assign ovf_in   = ovf_ff | ctrl_in.ovf;
   assign take     = enable && ctrl_in.valid;

   // Accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // New result wins over the hand-off of the previous one
         if (take && ctrl_in.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (take) begin
            if (ctrl_in.last) begin
               total_ff     <= '0;
               ovf_ff       <= 1'b0;
            end else begin
               total_ff <= total_in;
               ovf_ff   <= ovf_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && ctrl_in.last) begin
         rsp_total_ff <= total_in;
         rsp_ovf_ff   <= ovf_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.inversion_total = rsp_total_ff;
   assign rsp_if.overflowed      = rsp_ovf_ff;

   // Sequence end leaves clean accumulators behind
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (take && ctrl_in.last) |=> (total_ff == '0 && !ovf_ff))
      else $error("accumulators not cleared after sequence end");

   // A result is never produced while the previous one is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !take)
      else $error("row advanced into a held result");

endmodule

// ----- rtl/inversion_counter.sv -----
// Path: an accepted request is registered in the first cell, then in each
// further cell in turn, then in the tail's result register, where its result
// is held until it is taken.
// Throughput: one request per cycle; the row of cells is a systolic pipeline
// and stalls as a whole only while a finished result waits to be taken.
// Reset: synchronous, clears the element count, accumulators and slot valids;
// stored elements are not cleared.
module inversion_counter #(
   parameter int MAX_ELEMENTS = 64,
   parameter int VALUE_WIDTH  = 32
) (
   input  logic        clock,
   input  logic        reset,
   invc_req_if.sink    req_if,
   invc_rsp_if.source  rsp_if
);

   localparam int IDX_W     = $clog2(MAX_ELEMENTS);
   localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int GREATER_W = $clog2(MAX_ELEMENTS);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ELEMENTS);
   localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic                   enable;
   logic                   accept;
   logic [CNT_W-1:0]       count_ff;

   invc_pkg::ctrl_type     ctrl_w    [MAX_ELEMENTS+1];
   logic [IDX_W-1:0]       index_w   [MAX_ELEMENTS+1];
   logic [VALUE_WIDTH-1:0] key_w     [MAX_ELEMENTS+1];
   logic [GREATER_W-1:0]   greater_w [MAX_ELEMENTS+1];

   // Whole row advances unless a held result blocks the tail
   assign enable       = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = enable;
   assign accept       = req_if.valid && enable;

   // Entry: tag each request with its sequence position
   assign ctrl_w[0].valid = accept;
   assign ctrl_w[0].last  = req_if.last;
   assign ctrl_w[0].ovf   = (count_ff == CNT_FULL);
   assign index_w[0]      = count_ff[IDX_W-1:0];
   assign key_w[0]        = req_if.value ^ SIGN_BIT;
   assign greater_w[0]    = '0;

   // Position counter
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         if (req_if.last) begin
            count_ff <= '0;
         end else if (count_ff != CNT_FULL) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // Row of compare cells
   for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
      invc_cell #(
         .CELL_INDEX (k),
         .KEY_W      (VALUE_WIDTH),
         .IDX_W      (IDX_W),
         .GREATER_W  (GREATER_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (enable),
         .ctrl_in     (ctrl_w[k]),
         .index_in    (index_w[k]),
         .key_in      (key_w[k]),
         .greater_in  (greater_w[k]),
         .ctrl_out    (ctrl_w[k+1]),
         .index_out   (index_w[k+1]),
         .key_out     (key_w[k+1]),
         .greater_out (greater_w[k+1])
      );
   end

   invc_tail #(
      .GREATER_W (GREATER_W)
   ) u_tail (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .ctrl_in    (ctrl_w[MAX_ELEMENTS]),
      .greater_in (greater_w[MAX_ELEMENTS]),
      .rsp_if     (rsp_if)
   );

   // Position counter stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("element count beyond capacity");

   // A last request restarts the sequence
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.last) |=> (count_ff == '0))
      else $error("count not restarted after last request");

endmodule
